@@ rtl/core/utl_pkg.sv @@
// ----------------------------------------------------------------------------
// utl_pkg
// Shared types, constants and calendar helpers for the UTC to local time shift.
// ----------------------------------------------------------------------------
package utl_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int OFFSET_W = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // minute of day, 0..1439 after normalizing
    localparam int MOD_W    = 11;

    localparam logic [OFFSET_W-1:0] OFFSET_BIAS = 7'd48;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 7'd104;
    localparam logic [MOD_W-1:0]    MIN_PER_DAY = 11'd1440;

    // register index taken from paddr above the byte lanes
    localparam logic REG_OFFSET = 1'b0;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                ok;
    } t_utc_item;

    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                valid;
    } t_local_item;

    // month must already be clamped to 1..12
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd2:                     len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
                default:                  len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // gregorian rule without dividers: y%100 via y/4 divisible by 25
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-3:0] quarter;
        logic [24:0]       prod;
        logic [7:0]        q25;
        logic [YEAR_W-3:0] back;
        logic              div4;
        logic              div100;
        begin
            quarter = year[YEAR_W-1:2];
            prod    = 25'(quarter) * 25'd5243;
            q25     = prod[24:17];
            back    = 12'(q25) * 12'd25;
            div4    = (year[1:0] == 2'd0);
            div100  = div4 && (back == quarter);
            return (div4 && !div100) || (div100 && (year[3:2] == 2'd0));
        end
    endfunction

endpackage

@@ rtl/core/utl_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// utl_cfg_regs
// APB register bank holding the time zone offset in biased quarter hours.
// ----------------------------------------------------------------------------
module utl_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utl_pkg::APB_AW-1:0]    paddr,
    input  logic [utl_pkg::APB_DW-1:0]    pwdata,
    output logic [utl_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [utl_pkg::OFFSET_W-1:0]  o_offset
);
    import utl_pkg::*;

    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] n_offset;
    logic                reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[APB_AW-1];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_OFFSET);

    // writes above the top zone saturate
    assign n_offset = (pwdata[OFFSET_W-1:0] > OFFSET_MAX) ? OFFSET_MAX
                                                          : pwdata[OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_BIAS;
        end else if (wr_en) begin
            r_offset <= n_offset;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_OFFSET) begin
            prdata = APB_DW'(r_offset);
        end
    end

    assign pready   = 1'b1;
    assign o_offset = r_offset;

endmodule

@@ rtl/core/utl_convert.sv @@
// ----------------------------------------------------------------------------
// utl_convert
// Single-pass date and time arithmetic: offset, one day of rollover, h/m split.
// ----------------------------------------------------------------------------
module utl_convert (
    input  utl_pkg::t_utc_item                i_item,
    input  logic [utl_pkg::OFFSET_W-1:0]      i_offset,
    output utl_pkg::t_local_item              o_item
);
    import utl_pkg::*;

    logic [MONTH_W-1:0]  month;
    logic [MONTH_W-1:0]  prev_month;
    logic [MONTH_W-1:0]  next_month;
    logic [MOD_W-1:0]    mod_in;
    logic signed [12:0]  total;
    logic [MOD_W-1:0]    mod_out;
    logic                leap;
    logic [DAY_W-1:0]    dim_cur;
    logic [DAY_W-1:0]    dim_prev;
    logic [21:0]         hq_prod;
    logic [HOUR_W-1:0]   hour;
    logic [MOD_W-1:0]    hour_min;
    logic [MOD_W-1:0]    rem;

    always_comb begin
        month = i_item.month;
        if (month == 4'd0) begin
            month = MONTH_JAN;
        end else if (month > MONTH_DEC) begin
            month = MONTH_DEC;
        end
        prev_month = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;
        next_month = (month == MONTH_DEC) ? MONTH_JAN : month + 4'd1;

        leap     = is_leap(i_item.year);
        dim_cur  = days_in_month(month, leap);
        // january rolls back to december, whose length ignores the year
        dim_prev = days_in_month(prev_month, leap);

        mod_in = MOD_W'(i_item.hour) * 11'd60 + MOD_W'(i_item.minute);
        total  = $signed({2'b00, mod_in})
               + $signed(13'(i_offset) * 13'sd15)
               - $signed(13'(OFFSET_BIAS) * 13'sd15);

        o_item = '0;
        if (total < 0) begin
            mod_out = MOD_W'(total + 13'sd1440);
            if (i_item.day <= 5'd1) begin
                o_item.month = prev_month;
                o_item.day   = dim_prev;
            end else begin
                o_item.month = month;
                o_item.day   = i_item.day - 5'd1;
            end
        end else if (total >= $signed({2'b00, MIN_PER_DAY})) begin
            mod_out = MOD_W'(total - 13'sd1440);
            if (i_item.day >= dim_cur) begin
                o_item.month = next_month;
                o_item.day   = 5'd1;
            end else begin
                o_item.month = month;
                o_item.day   = i_item.day + 5'd1;
            end
        end else begin
            mod_out      = MOD_W'(total);
            o_item.month = month;
            o_item.day   = i_item.day;
        end

        // divide by 60 via reciprocal, exact for 0..1439
        hq_prod  = 22'(mod_out) * 22'd1093;
        hour     = hq_prod[20:16];
        hour_min = MOD_W'(hour) * 11'd60;
        rem      = mod_out - hour_min;

        o_item.hour   = hour;
        o_item.minute = rem[MINUTE_W-1:0];
        o_item.valid  = 1'b1;

        if (!i_item.ok) begin
            o_item = '0;
        end
    end

endmodule

@@ rtl/core/utc_to_local_time_shift.sv @@
// ----------------------------------------------------------------------------
// utc_to_local_time_shift
// Shifts a UTC date and time by a programmable zone offset, with day and month
// rollover, and returns local month, day, hour and minute.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  beat contents
//  in        input      i_in_valid / o_in_ready    utc year..minute, fields_ok
//  out       output     o_out_valid / i_out_ready  local month..minute, result_valid
//  cfg       input      apb psel/penable/pready    utc_offset_quarters at 0x0
//
//  each beat passes an input register, the date logic,
//  then a result register; one beat per cycle is sustained unless the output stalls
//  the result register frees up in the same cycle its beat is taken, so a
//  stall on the output stops the input only once both registers are full
//  synchronous active-low reset empties both stages and sets a zero offset
// ----------------------------------------------------------------------------
module utc_to_local_time_shift (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [utl_pkg::APB_AW-1:0]     paddr,
    input  logic [utl_pkg::APB_DW-1:0]     pwdata,
    output logic [utl_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [utl_pkg::YEAR_W-1:0]     i_utc_year,
    input  logic [utl_pkg::MONTH_W-1:0]    i_utc_month,
    input  logic [utl_pkg::DAY_W-1:0]      i_utc_day,
    input  logic [utl_pkg::HOUR_W-1:0]     i_utc_hour,
    input  logic [utl_pkg::MINUTE_W-1:0]   i_utc_minute,
    input  logic                           i_fields_ok,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [utl_pkg::MONTH_W-1:0]    o_local_month,
    output logic [utl_pkg::DAY_W-1:0]      o_local_day,
    output logic [utl_pkg::HOUR_W-1:0]     o_local_hour,
    output logic [utl_pkg::MINUTE_W-1:0]   o_local_minute,
    output logic                           o_result_valid
);
    import utl_pkg::*;

    logic [OFFSET_W-1:0] offset;
    t_utc_item           r_s1;
    logic                r_s1_valid;
    t_local_item         r_s2;
    logic                r_s2_valid;
    t_local_item         n_s2;
    logic                s1_ready;
    logic                s2_ready;

    utl_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_offset (offset)
    );

    utl_convert u_conv (
        .i_item   (r_s1),
        .i_offset (offset),
        .o_item   (n_s2)
    );

    assign s2_ready   = !r_s2_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1.year   <= i_utc_year;
            r_s1.month  <= i_utc_month;
            r_s1.day    <= i_utc_day;
            r_s1.hour   <= i_utc_hour;
            r_s1.minute <= i_utc_minute;
            r_s1.ok     <= i_fields_ok;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_out_valid    = r_s2_valid;
    assign o_local_month  = r_s2.month;
    assign o_local_day    = r_s2.day;
    assign o_local_hour   = r_s2.hour;
    assign o_local_minute = r_s2.minute;
    assign o_result_valid = r_s2.valid;

endmodule

@@ rtl/core/utl_checker.sv @@
// ----------------------------------------------------------------------------
// utl_checker
// Port-level checks on the local time shift, bound to the top level.
// ----------------------------------------------------------------------------
module utl_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [utl_pkg::APB_DW-1:0]     prdata,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [utl_pkg::MONTH_W-1:0]    o_local_month,
    input  logic [utl_pkg::DAY_W-1:0]      o_local_day,
    input  logic [utl_pkg::HOUR_W-1:0]     o_local_hour,
    input  logic [utl_pkg::MINUTE_W-1:0]   o_local_minute,
    input  logic                           o_result_valid
);
    import utl_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_local_month) && $stable(o_local_day)
            && $stable(o_local_hour) && $stable(o_local_minute)
            && $stable(o_result_valid))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_valid |-> o_local_month == '0
            && o_local_day == '0 && o_local_hour == '0 && o_local_minute == '0)
        else $error("invalid input gave nonzero fields");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_valid |-> o_local_hour < 5'd24
            && o_local_minute < 6'd60 && o_local_month != '0
            && o_local_month <= MONTH_DEC)
        else $error("local time out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_offset_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata <= APB_DW'(OFFSET_MAX))
        else $error("offset register above limit");

endmodule

bind utc_to_local_time_shift utl_checker u_utl_checker (.*);
